/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/dcte_pkg.sv */
// shared types and constants of the transmission estimate block
// no dependencies
package dcte_pkg;

  localparam int LEVEL_W   = 8;
  localparam int THR_W     = 9;
  localparam int TRANS_W   = 29;
  localparam int LEVEL_NUM = 1 << LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] ATM_MIN   = 8'd1;
  localparam logic [LEVEL_W-1:0] ATM_MAX   = 8'd254;
  localparam logic [LEVEL_W-1:0] ATM_RESET = 8'd128;
  localparam logic [THR_W-1:0]   THR_RESET = 9'd102;

  typedef enum logic [1:0] {
    REG_ATM0 = 2'd0,
    REG_ATM1 = 2'd1,
    REG_ATM2 = 2'd2,
    REG_THR  = 2'd3
  } reg_idx_t;

endpackage

/* hw/rtl/dcte_div.sv */
// three-stage fixed-point divider: reciprocal lookup, multiply, correction
// depends on dcte_pkg
module dcte_div import dcte_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [LEVEL_W-1:0]                num_mag,
  input  logic                              num_neg,
  input  logic [LEVEL_W-1:0]                den,
  output logic signed [LEVEL_W+FRAC_BITS:0] quot
);

  localparam int QW = LEVEL_W + FRAC_BITS;
  localparam int K  = QW;
  localparam int RW = K + 1;

  // floor(2^K / den) for every nonzero divisor code; code 0 gives 0
  logic [RW-1:0] recip_tab [LEVEL_NUM];

  for (genvar i = 0; i < LEVEL_NUM; i++) begin : g_recip
    localparam longint unsigned RV = (i == 0) ? 0 : ((64'd1 << K) / ((i == 0) ? 1 : i));
    assign recip_tab[i] = RW'(RV);
  end

  // stage 0
  logic [LEVEL_W-1:0] mag0;
  logic               neg0;
  logic [LEVEL_W-1:0] den0;
  logic [RW-1:0]      recip0;

  always_ff @(posedge clk) begin
    if (en) begin
      mag0   <= num_mag;
      neg0   <= num_neg;
      den0   <= den;
      recip0 <= recip_tab[den];
    end
  end

  // stage 1: estimate, low by at most one
  logic [LEVEL_W+RW-1:0] est_prod;
  logic [QW-1:0]         q0;
  logic [LEVEL_W-1:0]    mag1;
  logic                  neg1;
  logic [LEVEL_W-1:0]    den1;

  assign est_prod = LEVEL_W'(mag0) * recip0;

  always_ff @(posedge clk) begin
    if (en) begin
      q0   <= QW'(est_prod >> LEVEL_W);
      mag1 <= mag0;
      neg1 <= neg0;
      den1 <= den0;
    end
  end

  // stage 2: remainder check and sign
  logic [QW-1:0]         numer;
  logic [QW+LEVEL_W-1:0] qd;
  logic [QW+LEVEL_W-1:0] rem;
  logic [QW-1:0]         q;
  logic signed [QW:0]    qs;

  assign numer = {mag1, {FRAC_BITS{1'b0}}};
  assign qd    = q0 * den1;
  assign rem   = (QW+LEVEL_W)'(numer) - qd;
  assign q     = (rem >= (QW+LEVEL_W)'(den1)) ? q0 + 1'b1 : q0;
  assign qs    = signed'({1'b0, q});

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg1 ? -qs : qs;
    end
  end

endmodule

/* hw/rtl/dcte_mul.sv */
// correction product and output select, two register stages
// depends on dcte_pkg
module dcte_mul import dcte_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [LEVEL_W+FRAC_BITS:0] tb,
  input  logic signed [LEVEL_W+FRAC_BITS:0] td,
  input  logic                              corr,
  output logic signed [TRANS_W-1:0]         trans
);

  localparam int QW = LEVEL_W + FRAC_BITS;
  localparam int PW = 2 * (QW + 1);

  logic signed [PW-1:0] prod;
  logic signed [QW:0]   tb_d;
  logic signed [PW-1:0] prod_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= tb * td;
      tb_d <= tb;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign prod_sh = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      trans <= corr ? TRANS_W'(prod_sh) : TRANS_W'(tb_d);
    end
  end

endmodule

/* hw/rtl/dual_channel_transmission_estimate.sv */
// each accepted pixel beat gives its result beat at the end of the pipeline
// one pixel per cycle unless stalled; depth set by the three-stage reciprocal
//   divider followed by the product and output stages
// a stalled output freezes the whole pipeline and stalls the input
// reset (synchronous) clears the valid bits and loads register defaults
`include "assert_macros.svh"
module dual_channel_transmission_estimate import dcte_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic [LEVEL_W-1:0]        bright_level,
  input  logic [LEVEL_W-1:0]        dark_level,
  output logic                      trans_valid,
  input  logic                      trans_stall,
  output logic signed [TRANS_W-1:0] trans_ch0,
  output logic signed [TRANS_W-1:0] trans_ch1,
  output logic signed [TRANS_W-1:0] trans_ch2,
  output logic                      corrected
);

  localparam int QW    = LEVEL_W + FRAC_BITS;
  localparam int DEPTH = 5;

  // configuration registers
  logic [LEVEL_W-1:0] air_level [3];
  logic [THR_W-1:0]   correction_threshold;
  logic               cfg_write;
  reg_idx_t           cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      air_level[0]         <= ATM_RESET;
      air_level[1]         <= ATM_RESET;
      air_level[2]         <= ATM_RESET;
      correction_threshold <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_ATM0: air_level[0]         <= pwdata[LEVEL_W-1:0];
        REG_ATM1: air_level[1]         <= pwdata[LEVEL_W-1:0];
        REG_ATM2: air_level[2]         <= pwdata[LEVEL_W-1:0];
        REG_THR:  correction_threshold <= pwdata[THR_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ATM0: prdata = 32'(air_level[0]);
      REG_ATM1: prdata = 32'(air_level[1]);
      REG_ATM2: prdata = 32'(air_level[2]);
      REG_THR:  prdata = 32'(correction_threshold);
      default:  prdata = '0;
    endcase
  end

  // pipeline control
  logic             pipe_en;
  logic             accept;
  logic [DEPTH-1:0] valid_pipe;
  logic [DEPTH-1:0] corr_pipe;
  logic             corr_in;

  assign pipe_en     = !(valid_pipe[DEPTH-1] && trans_stall);
  assign pix_stall   = !pipe_en;
  assign accept      = pix_valid && !pix_stall;
  assign trans_valid = valid_pipe[DEPTH-1];
  assign corrected   = corr_pipe[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (pipe_en) begin
      valid_pipe <= {valid_pipe[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      corr_pipe <= {corr_pipe[DEPTH-2:0], corr_in};
    end
  end

  // correction test on signed bright minus dark
  logic signed [LEVEL_W+1:0] bd_diff;

  assign bd_diff = signed'({2'b00, bright_level}) - signed'({2'b00, dark_level});
  assign corr_in = bd_diff < signed'({1'b0, correction_threshold});

  // per channel datapath
  logic signed [TRANS_W-1:0] trans [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [LEVEL_W-1:0] atm;
    logic [LEVEL_W-1:0] tb_mag;
    logic               tb_neg;
    logic [LEVEL_W-1:0] tb_den;
    logic [LEVEL_W-1:0] td_mag;
    logic               td_neg;
    logic signed [QW:0] tb;
    logic signed [QW:0] td;

    assign atm    = (air_level[c] < ATM_MIN) ? ATM_MIN :
                    (air_level[c] > ATM_MAX) ? ATM_MAX : air_level[c];
    assign tb_neg = bright_level < atm;
    assign tb_mag = tb_neg ? atm - bright_level : bright_level - atm;
    assign tb_den = LEVEL_MAX - atm;
    assign td_neg = dark_level > atm;
    assign td_mag = td_neg ? dark_level - atm : atm - dark_level;

    dcte_div #(.FRAC_BITS(FRAC_BITS)) u_div_tb (
      .clk     (clk),
      .en      (pipe_en),
      .num_mag (tb_mag),
      .num_neg (tb_neg),
      .den     (tb_den),
      .quot    (tb)
    );

    dcte_div #(.FRAC_BITS(FRAC_BITS)) u_div_td (
      .clk     (clk),
      .en      (pipe_en),
      .num_mag (td_mag),
      .num_neg (td_neg),
      .den     (atm),
      .quot    (td)
    );

    dcte_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk   (clk),
      .en    (pipe_en),
      .tb    (tb),
      .td    (td),
      .corr  (corr_pipe[DEPTH-2]),
      .trans (trans[c])
    );
  end

  assign trans_ch0 = trans[0];
  assign trans_ch1 = trans[1];
  assign trans_ch2 = trans[2];

  `ASSERT_IMPLIES(a_stall_only_when_blocked, clk, rst, pix_stall, trans_valid && trans_stall)
  `ASSERT_NEXT(a_frozen_valid_bits, clk, rst, !pipe_en, $stable(valid_pipe))
  `ASSERT_NEXT(a_last_stage_reaches_out, clk, rst, pipe_en && valid_pipe[DEPTH-2], trans_valid)

endmodule

/* verif/testbench.sv */
// testbench for the dual-channel transmission estimate block: directed rows, then random
// pixel phases under changing register settings, checked against a behavioral predictor
// depends on dcte_pkg and dual_channel_transmission_estimate
`timescale 1ns / 100ps

module testbench;
  import dcte_pkg::*;

  localparam int FRAC_BITS = 12;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 5;
  localparam int PHASE_PIXELS = 200;

  typedef struct packed {
    logic [2:0][TRANS_W-1:0] t;
    logic corr;
  } trans_beat_t;

  typedef struct {
    bit is_cfg;
    reg_idx_t idx;
    logic [31:0] value;
    logic [LEVEL_W-1:0] b;
    logic [LEVEL_W-1:0] d;
    bit typed;
    logic signed [TRANS_W-1:0] t_exp;
    logic c_exp;
  } script_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid;
  logic pix_stall;
  logic [LEVEL_W-1:0] bright_level;
  logic [LEVEL_W-1:0] dark_level;
  logic trans_valid;
  logic trans_stall;
  logic signed [TRANS_W-1:0] trans_ch0;
  logic signed [TRANS_W-1:0] trans_ch1;
  logic signed [TRANS_W-1:0] trans_ch2;
  logic corrected;

  logic [LEVEL_W-1:0] atm_shadow [3];
  logic [THR_W-1:0] thr_shadow;
  trans_beat_t pending_trans [$];
  trans_beat_t head;
  script_row_t script [$];
  logic [2:0][TRANS_W-1:0] trans_got;

  bit steady;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int pixels_sent;
  int beats_checked;
  int mismatches;
  int reg_writes;

  assign trans_got = {trans_ch2, trans_ch1, trans_ch0};

  dual_channel_transmission_estimate #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .bright_level(bright_level), .dark_level(dark_level),
    .trans_valid(trans_valid), .trans_stall(trans_stall),
    .trans_ch0(trans_ch0), .trans_ch1(trans_ch1), .trans_ch2(trans_ch2),
    .corrected(corrected)
  );

  always #5 clk = ~clk;

  function automatic trans_beat_t estimate_transmission(logic [LEVEL_W-1:0] b,
                                                        logic [LEVEL_W-1:0] d);
    trans_beat_t r;
    longint a;
    longint tb;
    longint td;
    longint t;
    r.corr = (longint'(b) - longint'(d)) < longint'(thr_shadow);
    for (int c = 0; c < 3; c++) begin
      a = longint'(atm_shadow[c]);
      if (a < longint'(ATM_MIN)) a = longint'(ATM_MIN);
      if (a > longint'(ATM_MAX)) a = longint'(ATM_MAX);
      tb = ((longint'(b) - a) * (longint'(1) <<< FRAC_BITS)) / (longint'(LEVEL_MAX) - a);
      t = tb;
      if (r.corr) begin
        td = ((a - longint'(d)) * (longint'(1) <<< FRAC_BITS)) / a;
        t = (tb * td) >>> FRAC_BITS;
      end
      r.t[c] = t[TRANS_W-1:0];
    end
    return r;
  endfunction

  function automatic void row_pix(logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] d);
    script_row_t r;
    r = '{is_cfg: 1'b0, idx: REG_ATM0, value: '0, b: b, d: d, typed: 1'b0,
          t_exp: '0, c_exp: 1'b0};
    script.push_back(r);
  endfunction

  function automatic void row_typed(logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] d,
                                    logic signed [TRANS_W-1:0] t, logic c);
    script_row_t r;
    r = '{is_cfg: 1'b0, idx: REG_ATM0, value: '0, b: b, d: d, typed: 1'b1,
          t_exp: t, c_exp: c};
    script.push_back(r);
  endfunction

  function automatic void row_cfg(reg_idx_t idx, logic [31:0] value);
    script_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, value: value, b: '0, d: '0, typed: 1'b0,
          t_exp: '0, c_exp: 1'b0};
    script.push_back(r);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_pixel(input logic [LEVEL_W-1:0] b, input logic [LEVEL_W-1:0] d,
                            input bit typed, input trans_beat_t typed_exp);
    while (!steady && $urandom_range(0, 99) < 24) begin
      pix_valid = 1'b0;
      @(negedge clk);
    end
    pix_valid = 1'b1;
    bright_level = b;
    dark_level = d;
    do @(posedge clk); while (pix_stall);
    pending_trans.push_back(typed ? typed_exp : estimate_transmission(b, d));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix_valid = 1'b0;
    while (pending_trans.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ATM0: atm_shadow[0] = value[LEVEL_W-1:0];
      REG_ATM1: atm_shadow[1] = value[LEVEL_W-1:0];
      REG_ATM2: atm_shadow[2] = value[LEVEL_W-1:0];
      REG_THR:  thr_shadow = value[THR_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // receiver side: random stall unless steady, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      trans_stall = 1'b1;
      hold_left--;
    end else if (steady) begin
      trans_stall = 1'b0;
    end else begin
      trans_stall = ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    if (!rst && trans_valid && !trans_stall) begin
      if (pending_trans.size() == 0) begin
        $display("%0t: result beat with no expectation: %0d %0d %0d corrected %0b",
                 $time, trans_ch0, trans_ch1, trans_ch2, corrected);
        mismatches++;
      end else begin
        head = pending_trans.pop_front();
        beats_checked++;
        for (int c = 0; c < 3; c++) begin
          if (trans_got[c] !== head.t[c]) begin
            $display("%0t: trans_ch%0d expected %0d actual %0d", $time, c,
                     $signed(head.t[c]), $signed(trans_got[c]));
            mismatches++;
          end
        end
        if (corrected !== head.corr) begin
          $display("%0t: corrected expected %0b actual %0b", $time, head.corr, corrected);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_valid && !pix_stall) || (trans_valid && !trans_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no beat", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    trans_beat_t typed_exp;
    logic [LEVEL_W-1:0] b;
    logic [LEVEL_W-1:0] d;
    logic [31:0] v;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_valid = 1'b0;
    bright_level = '0;
    dark_level = '0;
    trans_stall = 1'b0;
    steady = 1'b0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    pixels_sent = 0;
    beats_checked = 0;
    mismatches = 0;
    reg_writes = 0;
    for (int c = 0; c < 3; c++) atm_shadow[c] = ATM_RESET;
    thr_shadow = THR_RESET;

    // register defaults
    row_typed(8'd255, 8'd0, 29'sd4096, 1'b0);
    row_typed(8'd128, 8'd128, 29'sd0, 1'b1);
    row_pix(8'd0, 8'd255);
    row_pix(8'd0, 8'd0);
    row_pix(8'd255, 8'd255);
    row_pix(8'd170, 8'd85);
    row_pix(8'd85, 8'd170);
    // highest atmospheric light, threshold zero
    row_cfg(REG_ATM0, 32'd254);
    row_cfg(REG_ATM1, 32'd254);
    row_cfg(REG_ATM2, 32'd254);
    row_cfg(REG_THR, 32'd0);
    row_typed(8'd0, 8'd0, -29'sd1040384, 1'b0);
    row_typed(8'd255, 8'd0, 29'sd4096, 1'b0);
    row_pix(8'd0, 8'd255);
    // out-of-range light levels clamp, threshold of 256 or more corrects all
    row_cfg(REG_ATM0, 32'd0);
    row_cfg(REG_ATM1, 32'd255);
    row_cfg(REG_ATM2, 32'd1);
    row_cfg(REG_THR, 32'd511);
    row_pix(8'd255, 8'd255);
    row_pix(8'd0, 8'd0);
    row_pix(8'd255, 8'd0);
    row_cfg(REG_THR, 32'd256);
    row_pix(8'd255, 8'd0);
    row_pix(8'd0, 8'd255);
    row_cfg(REG_THR, 32'd255);
    row_pix(8'd255, 8'd0);
    row_pix(8'd254, 8'd0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_idle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        typed_exp.t = {3{script[i].t_exp}};
        typed_exp.corr = script[i].c_exp;
        send_pixel(script[i].b, script[i].d, script[i].typed, typed_exp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady = (p == 2);
      for (int c = 0; c < 3; c++) begin
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'd254;
            default: v = 32'd255;
          endcase
        end else begin
          v = $urandom_range(0, 255);
        end
        write_reg(reg_idx_t'(c), v);
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd255;
          2: v = 32'd256;
          3: v = 32'd257;
          default: v = 32'd511;
        endcase
      end else begin
        v = $urandom_range(0, 300);
      end
      write_reg(REG_THR, v);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (p == 3 && n == 20) hold_asks++;
        d = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0) b = $urandom_range(d, 255);
        else b = $urandom_range(0, 255);
        send_pixel(b, d, 1'b0, typed_exp);
      end
    end

    pix_valid = 1'b0;
    steady = 1'b0;
    while (pending_trans.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d pixels over %0d register writes, %0d result beats compared",
             pixels_sent, reg_writes, beats_checked);
    $display("covered clamped light levels, thresholds 0 to 511, random stalls and a long hold-off");
    if (mismatches == 0 && pending_trans.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
